/* rtl/tcce_pkg.sv */
package tcce_pkg;

  // Field widths of the input and result items.
  localparam int OPC_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int CLR_W  = 4;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;
  localparam logic [CLR_W-1:0] FG_RESET = 4'd2;
  localparam logic [CLR_W-1:0] BG_RESET = 4'd0;

  // Character codes with a control meaning.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Cell values: space with attribute 0x02 after reset, space with a zero
  // attribute for a row uncovered by a scroll.
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0220;
  localparam logic [CELL_W-1:0] BLANK_SCROLL = 16'h0020;

  // Depth of the command queue between the front and the back end.
  localparam int QDEPTH = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_PUT    = 2'd0,
    OP_SET    = 2'd1,
    OP_PUT_AT = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CC_PRINT,
    CC_NL,
    CC_CR,
    CC_TAB,
    CC_BS
  } char_class_t;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
  } out_item_t;

  // Classified command as it travels through the queue. Column and row are
  // already saturated to the screen size.
  typedef struct packed {
    opcode_t           op;
    char_class_t       cls;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/tcce_front.sv */
module tcce_front import tcce_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  input  logic     clearing,
  output logic     push,
  output cmd_t     cmd
);

  assign in_stall = q_stat.full || clearing;
  assign push     = in_valid && !in_stall;

  always_comb begin
    cmd.op  = opcode_t'(in_data.opcode);
    cmd.ch  = in_data.char_code;
    cmd.col = (int'(in_data.col) >= COLS) ? COL_W'(COLS - 1) : in_data.col;
    cmd.row = (int'(in_data.row) >= ROWS) ? ROW_W'(ROWS - 1) : in_data.row;
    case (in_data.char_code)
      CH_NL:   cmd.cls = CC_NL;
      CH_CR:   cmd.cls = CC_CR;
      CH_TAB:  cmd.cls = CC_TAB;
      CH_BS:   cmd.cls = CC_BS;
      default: cmd.cls = CC_PRINT;
    endcase
  end

endmodule

/* rtl/tcce_queue.sv */
module tcce_queue import tcce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  cmd_t          slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign stat.full  = (count == NW'(QDEPTH));
  assign stat.empty = (count == '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/tcce_back.sv */
module tcce_back import tcce_pkg::*; #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STEP = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  q_stat_t          q_stat,
  input  cmd_t             q_head,
  output logic             pop,
  input  logic [CLR_W-1:0] fg_color,
  input  logic [CLR_W-1:0] bg_color,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  localparam int CW    = $clog2(COLS);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int TW    = CW + 2;
  localparam int NRW   = RW + 2;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_BLANK  = 5'b10000
  } state_t;

  state_t state;
  cmd_t   cmd;

  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [RW-1:0] base;
  logic [AW-1:0] sweep_addr;
  logic [CW-1:0] blank_cnt;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data;

  logic              is_put;
  logic [CW-1:0]     pos_col;
  logic [RW-1:0]     pos_row;
  logic [CW-1:0]     new_col;
  logic [RW-1:0]     new_row;
  logic [1:0]        row_inc;
  logic              row_dec;
  logic [NRW-1:0]    row_sum;
  logic [TW-1:0]     tab_sum;
  logic              scroll;
  logic              wr_en;
  logic [CW-1:0]     wcol;
  logic [RW-1:0]     wrow;
  logic [CHAR_W-1:0] wr_char;
  logic [RW:0]       phys_sum;
  logic [RW-1:0]     phys_row;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     base_start;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_IDLE) && !q_stat.empty && (!out_valid || !out_stall);
  assign is_put   = (cmd.op == OP_PUT) || (cmd.op == OP_PUT_AT);

  // Cursor update and cell address of the command being executed.
  always_comb begin
    pos_col = (cmd.op == OP_PUT) ? cur_col : CW'(cmd.col);
    pos_row = (cmd.op == OP_PUT) ? cur_row : RW'(cmd.row);
    new_col = pos_col;
    row_inc = 2'd0;
    row_dec = 1'b0;
    wr_en   = 1'b0;
    wcol    = pos_col;
    wrow    = pos_row;
    wr_char = cmd.ch;
    tab_sum = TW'(pos_col) + TW'(TAB_STEP);
    // Only the put commands interpret the character; set and read use the
    // position exactly as given.
    if (is_put) begin
      case (cmd.cls)
        CC_PRINT: begin
          wr_en = 1'b1;
          if (pos_col == CW'(COLS - 1)) begin
            new_col = '0;
            row_inc = 2'd1;
          end else begin
            new_col = pos_col + 1'b1;
          end
        end
        CC_NL: begin
          new_col = '0;
          row_inc = 2'd1;
        end
        CC_CR: begin
          new_col = '0;
        end
        CC_TAB: begin
          if (tab_sum >= TW'(2 * COLS)) begin
            new_col = CW'(tab_sum - TW'(2 * COLS));
            row_inc = 2'd2;
          end else if (tab_sum >= TW'(COLS)) begin
            new_col = CW'(tab_sum - TW'(COLS));
            row_inc = 2'd1;
          end else begin
            new_col = CW'(tab_sum);
          end
        end
        CC_BS: begin
          // Backspace at the top left corner leaves everything as it is.
          if (pos_col != '0) begin
            new_col = pos_col - 1'b1;
            wr_en   = 1'b1;
            wcol    = pos_col - 1'b1;
            wr_char = CH_SPACE;
          end else if (pos_row != '0) begin
            new_col = CW'(COLS - 1);
            row_dec = 1'b1;
            wr_en   = 1'b1;
            wcol    = CW'(COLS - 1);
            wrow    = pos_row - 1'b1;
            wr_char = CH_SPACE;
          end
        end
        default: ;
      endcase
    end

    row_sum = NRW'(pos_row) + NRW'(row_inc);
    scroll  = !row_dec && (row_sum >= NRW'(ROWS));
    if (row_dec) begin
      new_row = pos_row - 1'b1;
    end else if (scroll) begin
      // One scroll only; if the cursor is still past the end it holds at
      // the last cell.
      if ((row_sum - NRW'(1)) >= NRW'(ROWS)) begin
        new_row = RW'(ROWS - 1);
        new_col = CW'(COLS - 1);
      end else begin
        new_row = RW'(row_sum - NRW'(1));
      end
    end else begin
      new_row = RW'(row_sum);
    end

    // The screen is a ring of rows; base is the physical row shown on top.
    phys_sum = (RW + 1)'(wrow) + (RW + 1)'(base);
    if (phys_sum >= (RW + 1)'(ROWS)) begin
      phys_row = RW'(phys_sum - (RW + 1)'(ROWS));
    end else begin
      phys_row = phys_sum[RW-1:0];
    end
    addr       = AW'(phys_row) * AW'(COLS) + AW'(wcol);
    base_start = AW'(base) * AW'(COLS);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = {bg_color, fg_color, wr_char};
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr;
        mem_wdata = RESET_CELL;
      end
      ST_EXEC: begin
        mem_we = is_put && wr_en;
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr;
        mem_wdata = BLANK_SCROLL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[addr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_head;
    end
    if (state == ST_EXEC) begin
      out_data.cell_data <= '0;
      if (cmd.op == OP_SET) begin
        out_data.cursor_col <= COL_W'(pos_col);
        out_data.cursor_row <= ROW_W'(pos_row);
        out_data.scrolled   <= 1'b0;
      end else begin
        out_data.cursor_col <= COL_W'(new_col);
        out_data.cursor_row <= ROW_W'(new_row);
        out_data.scrolled   <= scroll;
      end
    end
    if (state == ST_RDWAIT) begin
      out_data.cursor_col <= COL_W'(cur_col);
      out_data.cursor_row <= ROW_W'(cur_row);
      out_data.scrolled   <= 1'b0;
      out_data.cell_data  <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sweep_addr <= '0;
      blank_cnt  <= '0;
      cur_col    <= '0;
      cur_row    <= '0;
      base       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd.op == OP_READ) begin
            state <= ST_RDWAIT;
          end else if (cmd.op == OP_SET) begin
            cur_col   <= pos_col;
            cur_row   <= pos_row;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            cur_col   <= new_col;
            cur_row   <= new_row;
            out_valid <= 1'b1;
            if (scroll) begin
              base       <= (base == RW'(ROWS - 1)) ? '0 : base + 1'b1;
              sweep_addr <= base_start;
              blank_cnt  <= '0;
              state      <= ST_BLANK;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_RDWAIT: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_BLANK: begin
          sweep_addr <= sweep_addr + 1'b1;
          blank_cnt  <= blank_cnt + 1'b1;
          if (blank_cnt == CW'(COLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/text_console_char_engine_core.sv */
// Character-cell text console of COLS x ROWS cells, 16 bits each: the
// character byte in the low half and the attribute {bg_color, fg_color} in
// the high half. Each input item is one command: put a character at the
// cursor (newline, carriage return, tab and backspace are interpreted), set
// the cursor, put a character at a given position, or read one cell; each
// item gives exactly one result item with the cursor after the command, a
// scroll flag and, for a read, the cell contents. The execute unit first
// fetches an item from the command queue, then updates the screen memory
// and the cursor; a read adds a further step for the registered memory
// read. An item that scrolls the screen then occupies the execute unit
// while the new bottom row is blanked, one cell per cycle through the
// single write port of the screen memory; the screen itself is a ring
// of rows, so a scroll moves no data. After reset the execute unit
// sweeps all COLS*ROWS cells of the memory to spaces with attribute
// 0x02, and input
// is stalled during that sweep. A two-entry command queue lets new items
// be taken while the execute unit works or while a result waits in the
// output register. Configuration writes are always ready and should only
// be made while the block is idle.
module text_console_char_engine_core import tcce_pkg::*; #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STEP = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CLR_W-1:0]     cfg_data
);

  logic [CLR_W-1:0] fg_color;
  logic [CLR_W-1:0] bg_color;
  logic             clearing;
  logic             push;
  logic             pop;
  cmd_t             push_cmd;
  cmd_t             q_head;
  q_stat_t          q_stat;

  // Color registers; the block never blocks a configuration write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= FG_RESET;
      bg_color <= BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FG:  fg_color <= cfg_data;
        CFG_BG:  bg_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end saturates the position and classifies the character.
  tcce_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .clearing (clearing),
    .push     (push),
    .cmd      (push_cmd)
  );

  tcce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // The back end owns the screen memory, the cursor and the result register.
  tcce_back #(
    .COLS     (COLS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .pop       (pop),
    .fg_color  (fg_color),
    .bg_color  (bg_color),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // No result can appear while the memory is still being swept after reset.
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid)
    else $error("result produced during the clearing sweep");

  // Reset always restarts the clearing sweep with an empty result register.
  a_reset_starts_clear: assert property (@(posedge clk)
    rst |=> (clearing && !out_valid))
    else $error("reset did not restart the clearing sweep");

  // The queue can never report full and empty together.
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !q_stat.empty)
    else $error("command queue status is inconsistent");

endmodule
